### hw/rtl/bdph_pkg.sv
// Shared types and constants for the button debounce / press-hold block.
package bdph_pkg;

  localparam int TIME_BITS     = 32;
  localparam int DEB_BITS      = 16;
  localparam int HOLD_BITS     = 32;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [DEB_BITS-1:0]  DEBOUNCE_RESET = DEB_BITS'(20);
  localparam logic [HOLD_BITS-1:0] HOLD_RESET     = HOLD_BITS'(1200);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ACTIVE_HIGH = 2'd0,
    REG_DEBOUNCE_MS = 2'd1,
    REG_HOLD_MS     = 2'd2,
    REG_HOLD_ENABLE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                 active_high;
    logic [DEB_BITS-1:0]  debounce_ms;
    logic [HOLD_BITS-1:0] hold_ms;
    logic                 hold_enable;
  } cfg_t;

  typedef struct packed {
    logic press_begin;
    logic click_end;
    logic hold_begin;
    logic hold_end;
    logic is_down;
  } res_t;

endpackage

### hw/rtl/button_debounce_press_hold_core.sv
// Top level: input register, debounce/event core and result register.
//
// Polls enter on the in channel (in_valid/in_ready) as pin_level plus a
// free-running millisecond stamp now_ms. Every poll yields exactly one
// result on the out channel (out_valid/out_ready): press_begin, click_end,
// hold_begin, hold_end (at most one set) and is_down, the debounced level.
// Registers are written on the cfg channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data): 0 polarity, 1 debounce time, 2 hold time, 3 hold enable.
// cfg_ready is always high; write only while no poll is in flight.
//
// A poll is accepted into the input register, evaluated by the core from
// there, and its result is captured in the result register. Throughput is
// one poll per cycle while out_ready takes each result; the only loop is
// the state update in the core.
// When out_ready is low the result register holds, the input register
// still takes one more poll, then in_ready drops until the result drains.
// Synchronous reset empties both registers, restores register defaults
// (active low, 20 ms debounce, 1200 ms hold, hold off) and clears state.
module button_debounce_press_hold_core
  import bdph_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     pin_level,
  input  logic [TIME_BITS-1:0]     now_ms,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     press_begin,
  output logic                     click_end,
  output logic                     hold_begin,
  output logic                     hold_end,
  output logic                     is_down,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t                 cfg;
  res_t                 res;
  logic                 in_full;
  logic                 in_pin;
  logic [TIME_BITS-1:0] in_now;
  logic                 advance;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_pin <= pin_level;
      in_now <= now_ms;
    end
  end

  bdph_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bdph_event_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .pin_level (in_pin),
    .now_ms    (in_now),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      press_begin <= res.press_begin;
      click_end   <= res.click_end;
      hold_begin  <= res.hold_begin;
      hold_end    <= res.hold_end;
      is_down     <= res.is_down;
    end
  end

endmodule

### hw/rtl/bdph_cfg_regs.sv
// Configuration register file: polarity, debounce time, hold time, hold enable.
module bdph_cfg_regs
  import bdph_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                     cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_high <= 1'b0;
      cfg.debounce_ms <= DEBOUNCE_RESET;
      cfg.hold_ms     <= HOLD_RESET;
      cfg.hold_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ACTIVE_HIGH: cfg.active_high <= cfg_data[0];
        REG_DEBOUNCE_MS: cfg.debounce_ms <= cfg_data[DEB_BITS-1:0];
        REG_HOLD_MS:     cfg.hold_ms     <= cfg_data[HOLD_BITS-1:0];
        REG_HOLD_ENABLE: cfg.hold_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/bdph_event_core.sv
// Debounce state and event logic: one poll evaluated per advance.
module bdph_event_core
  import bdph_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 pin_level,
  input  logic [TIME_BITS-1:0] now_ms,
  input  cfg_t                 cfg,
  output res_t                 res
);

  logic                 last_raw;
  logic [TIME_BITS-1:0] stable_since;
  logic                 debounced;
  logic [TIME_BITS-1:0] press_stamp;
  logic                 hold_fired;

  logic                 debounced_next;
  logic [TIME_BITS-1:0] press_stamp_next;
  logic                 hold_fired_next;

  logic                 pressed;
  logic [TIME_BITS-1:0] since;
  logic [TIME_BITS-1:0] stable_el;
  logic [TIME_BITS-1:0] hold_el;
  logic                 deb_ok;
  logic                 hold_ok;

  assign pressed   = cfg.active_high ? pin_level : ~pin_level;
  // raw change restarts the stamp at this poll's time
  assign since     = (pressed != last_raw) ? now_ms : stable_since;
  assign stable_el = now_ms - since;
  assign hold_el   = now_ms - press_stamp;
  assign deb_ok    = stable_el > TIME_BITS'(cfg.debounce_ms);
  assign hold_ok   = hold_el > TIME_BITS'(cfg.hold_ms);

  always_comb begin
    debounced_next   = debounced;
    press_stamp_next = press_stamp;
    hold_fired_next  = hold_fired;
    res              = '0;
    if (deb_ok) begin
      if (pressed != debounced) begin
        debounced_next = pressed;
        if (pressed) begin
          press_stamp_next = since;
          res.press_begin  = 1'b1;
        end else if (!hold_fired) begin
          res.click_end = 1'b1;
        end else begin
          res.hold_end    = 1'b1;
          hold_fired_next = 1'b0;
        end
      end else if (debounced && cfg.hold_enable && !hold_fired && hold_ok) begin
        res.hold_begin  = 1'b1;
        hold_fired_next = 1'b1;
      end
    end
    res.is_down = debounced_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw     <= 1'b0;
      stable_since <= '0;
      debounced    <= 1'b0;
      press_stamp  <= '0;
      hold_fired   <= 1'b0;
    end else if (advance) begin
      last_raw     <= pressed;
      stable_since <= since;
      debounced    <= debounced_next;
      press_stamp  <= press_stamp_next;
      hold_fired   <= hold_fired_next;
    end
  end

  // a fired hold is always cleared by the release that ends the press
  a_hold_implies_down: assert property (@(posedge clk) disable iff (rst)
    hold_fired |-> debounced)
    else $error("hold_fired set while not debounced-pressed");

  a_events_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({res.press_begin, res.click_end, res.hold_begin, res.hold_end}))
    else $error("more than one event in a poll");

  a_hold_sets_flag: assert property (@(posedge clk) disable iff (rst)
    advance && res.hold_begin |=> hold_fired && debounced)
    else $error("hold_begin did not latch hold_fired");

  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    advance && (res.click_end || res.hold_end) |=> !debounced && !hold_fired)
    else $error("release left pressed state behind");

endmodule

### verif/tb_button_debounce_press_hold_core.sv
// Self-checking testbench for button_debounce_press_hold_core: polls checked vs a predictor.
module tb_button_debounce_press_hold_core;
  timeunit 1ns;
  timeprecision 1ps;
  import bdph_pkg::*;

  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic                 level;
    logic [TIME_BITS-1:0] ts;
    bit                   drain;
  } poll_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     pin_level = 1'b0;
  logic [TIME_BITS-1:0]     now_ms = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     press_begin;
  logic                     click_end;
  logic                     hold_begin;
  logic                     hold_end;
  logic                     is_down;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  button_debounce_press_hold_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pin_level  (pin_level),
    .now_ms     (now_ms),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .press_begin(press_begin),
    .click_end  (click_end),
    .hold_begin (hold_begin),
    .hold_end   (hold_end),
    .is_down    (is_down),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  poll_t polls_to_send[$];
  res_t  poll_results_due[$];
  int    idle_pct = 0;
  int    stall_pct = 0;
  logic  in_taken = 1'b0;
  int    n_err = 0;
  int    quiet_cycles = 0;

  // predictor copy of registers and state
  logic                 pol_high;
  logic [DEB_BITS-1:0]  deb_time;
  logic [HOLD_BITS-1:0] hold_lim;
  logic                 hold_on;
  logic                 raw_dn;
  logic [TIME_BITS-1:0] stable_t;
  logic                 deb_dn;
  logic [TIME_BITS-1:0] stamp_t;
  logic                 held;

  // stimulus generator view of the current settings
  logic                 gen_ah = 1'b0;
  int unsigned          gen_deb = 20;
  logic [31:0]          gen_hold = 1200;
  logic [31:0]          t_now = '0;
  int                   n_added = 0;
  bit                   drain_next = 1'b0;

  function automatic res_t predict_poll(logic lvl, logic [TIME_BITS-1:0] ts);
    res_t                 r;
    logic                 down;
    logic [TIME_BITS-1:0] dt;
    r = '0;
    down = pol_high ? lvl : ~lvl;
    if (down != raw_dn) stable_t = ts;
    raw_dn = down;
    dt = ts - stable_t;
    if (dt > TIME_BITS'(deb_time)) begin
      if (down != deb_dn) begin
        deb_dn = down;
        if (down) begin
          stamp_t = stable_t;
          r.press_begin = 1'b1;
        end else if (!held) begin
          r.click_end = 1'b1;
        end else begin
          r.hold_end = 1'b1;
          held = 1'b0;
        end
      end else if (deb_dn && hold_on && !held) begin
        dt = ts - stamp_t;
        if (dt > TIME_BITS'(hold_lim)) begin
          r.hold_begin = 1'b1;
          held = 1'b1;
        end
      end
    end
    r.is_down = deb_dn;
    return r;
  endfunction

  task automatic check_bit(string fname, logic want, logic got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0b, actual %0b", $time, fname, want, got);
      n_err++;
    end
  endtask

  // monitor and scoreboard
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      pol_high  = 1'b0;
      deb_time  = DEBOUNCE_RESET;
      hold_lim  = HOLD_RESET;
      hold_on   = 1'b0;
      raw_dn    = 1'b0;
      stable_t  = '0;
      deb_dn    = 1'b0;
      stamp_t   = '0;
      held      = 1'b0;
      in_taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_ACTIVE_HIGH: pol_high  = cfg_data[0];
          REG_DEBOUNCE_MS: deb_time  = cfg_data[DEB_BITS-1:0];
          REG_HOLD_MS:     hold_lim  = cfg_data[HOLD_BITS-1:0];
          REG_HOLD_ENABLE: hold_on   = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) poll_results_due.push_back(predict_poll(pin_level, now_ms));
      if (out_valid && out_ready) begin
        if (poll_results_due.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %b",
                   $time, {press_begin, click_end, hold_begin, hold_end, is_down});
          n_err++;
        end else begin
          want = poll_results_due.pop_front();
          check_bit("press_begin", want.press_begin, press_begin);
          check_bit("click_end", want.click_end, click_end);
          check_bit("hold_begin", want.hold_begin, hold_begin);
          check_bit("hold_end", want.hold_end, hold_end);
          check_bit("is_down", want.is_down, is_down);
        end
      end
      in_taken <= in_valid && in_ready;
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t ns: watchdog expired", $time);
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // poll driver and result sink
  always @(negedge clk) begin
    poll_t p;
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
      if (!in_valid || in_taken) begin
        if (polls_to_send.size() != 0 &&
            (!polls_to_send[0].drain || poll_results_due.size() == 0) &&
            $urandom_range(0, 99) >= idle_pct) begin
          p = polls_to_send.pop_front();
          in_valid  <= 1'b1;
          pin_level <= p.level;
          now_ms    <= p.ts;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic add_poll(logic lv, logic [31:0] ts);
    poll_t p;
    p.level = lv;
    p.ts    = ts;
    p.drain = drain_next || ($urandom_range(0, 63) == 0);
    drain_next = 1'b0;
    polls_to_send.push_back(p);
    t_now = ts;
    n_added++;
  endtask

  function automatic logic [31:0] short_step();
    return $urandom_range(0, gen_deb / 2 + 1);
  endfunction

  task automatic bounce();
    repeat ($urandom_range(0, 4)) add_poll(1'($urandom_range(0, 1)), t_now + short_step());
  endtask

  // stable level; second poll lands within one ms of the debounce boundary
  task automatic settle(logic lv, output logic [31:0] t0);
    add_poll(lv, t_now + short_step());
    t0 = t_now;
    add_poll(lv, t0 + gen_deb + $urandom_range(0, 2) - 1);
    repeat ($urandom_range(0, 2)) add_poll(lv, t_now + short_step());
  endtask

  task automatic gen_polls(int n);
    logic [31:0] t0;
    logic [31:0] t_rel;
    int          goal;
    bit          forced;
    goal   = n_added + n;
    forced = 1'b0;
    while (n_added < goal) begin
      if (!forced && n_added >= goal - n / 2) begin
        drain_next = 1'b1;
        forced = 1'b1;
      end
      case ($urandom_range(0, 9))
        0: add_poll(1'($urandom_range(0, 1)), $urandom());
        1: begin
          // too short to debounce, or time stepping backward
          bounce();
          add_poll(1'($urandom_range(0, 1)), t_now - $urandom_range(1, 50));
        end
        default: begin
          bounce();
          settle(gen_ah, t0);
          if ($urandom_range(0, 2) != 0) begin
            repeat ($urandom_range(1, 3)) begin
              case ($urandom_range(0, 3))
                0: begin
                  add_poll(!gen_ah, t_now + 1);
                  add_poll(gen_ah, t_now + short_step());
                end
                3: add_poll(gen_ah, t_now + $urandom());
                default: add_poll(gen_ah, t0 + gen_hold + $urandom_range(0, 2) - 1);
              endcase
            end
          end
          bounce();
          settle(!gen_ah, t_rel);
        end
      endcase
    end
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
      #1;
    end while (polls_to_send.size() != 0 || in_valid || poll_results_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_BITS-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // upper data bits carry junk on the narrow registers
  task automatic set_config(logic ah, int unsigned deb, logic [31:0] hold, logic hen);
    write_reg(REG_ACTIVE_HIGH, {31'($urandom()), ah});
    write_reg(REG_DEBOUNCE_MS, {16'($urandom()), 16'(deb)});
    write_reg(REG_HOLD_MS, hold);
    write_reg(REG_HOLD_ENABLE, {31'($urandom()), hen});
    @(negedge clk);
    cfg_valid <= 1'b0;
    gen_ah   = ah;
    gen_deb  = deb;
    gen_hold = hold;
    @(posedge clk);
  endtask

  task automatic run_phase(logic ah, int unsigned deb, logic [31:0] hold, logic hen,
                           int idle_p, int stall_p, logic [31:0] t_start, int n);
    wait_idle();
    set_config(ah, deb, hold, hen);
    idle_pct  <= idle_p;
    stall_pct <= stall_p;
    t_now = t_start;
    gen_polls(n);
  endtask

  initial begin
    // reset settings: active low, 20 ms debounce, hold off
    add_poll(1'b1, 32'd0);
    add_poll(1'b0, 32'd5);
    add_poll(1'b0, 32'd25);
    add_poll(1'b0, 32'd26);
    add_poll(1'b0, 32'd2000);
    add_poll(1'b1, 32'd2001);
    add_poll(1'b0, 32'd2005);
    add_poll(1'b1, 32'd2010);
    add_poll(1'b1, 32'd2031);
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // hold on, press across the timestamp wrap
    wait_idle();
    set_config(1'b0, 20, 32'd50, 1'b1);
    add_poll(1'b0, 32'hFFFF_FFF0);
    add_poll(1'b0, 32'd5);
    add_poll(1'b0, 32'd40);
    add_poll(1'b0, 32'hFFFF_FFFF);
    add_poll(1'b1, 32'hFFFF_FFFF);
    add_poll(1'b1, 32'd21);
    add_poll(1'b0, 32'd100);
    add_poll(1'b0, 32'd121);
    add_poll(1'b0, 32'd200);

    // hold disabled after it fired: release still ends the hold
    wait_idle();
    set_config(1'b0, 20, 32'd50, 1'b0);
    add_poll(1'b1, 32'd210);
    add_poll(1'b1, 32'd231);

    // polarity flip, then a backward timestamp
    wait_idle();
    set_config(1'b1, 20, 32'd50, 1'b0);
    add_poll(1'b1, 32'd240);
    add_poll(1'b1, 32'd0);
    add_poll(1'b0, 32'd0);
    add_poll(1'b0, 32'd100);

    run_phase(1'b1, 5, 32'd40, 1'b1, 0, 0, $urandom(), 104);
    run_phase(1'b0, 0, 32'd0, 1'b1, 55, 0, $urandom(), 104);
    run_phase(1'b1, 65535, 32'hFFFF_FFFF, 1'b1, 0, 55, $urandom(), 104);
    run_phase(1'b0, 3, 32'd25, 1'b0, 31, 31, $urandom(), 104);
    run_phase(1'b1, 20, 32'd1200, 1'b1, 55, 0, $urandom(), 104);
    run_phase(1'b0, 65535, 32'd0, 1'b1, 31, 31, 32'hFFFF_FF00, 104);

    wait_idle();
    repeat (8) @(negedge clk);
    if (n_err == 0 && poll_results_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### button_debounce_press_hold_core.f
hw/rtl/bdph_pkg.sv
hw/rtl/bdph_cfg_regs.sv
hw/rtl/bdph_event_core.sv
hw/rtl/button_debounce_press_hold_core.sv
verif/tb_button_debounce_press_hold_core.sv
